/* hdl/point_to_depth_image_projector_macros.svh */
// Assertion macros for the depth image projector checker.
// Every macro samples on clk; the reset-qualified forms are disabled while rst_n is low.
`ifndef POINT_TO_DEPTH_IMAGE_PROJECTOR_MACROS_SVH
`define POINT_TO_DEPTH_IMAGE_PROJECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PTDI_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("ptdi assertion failed");

// Next-cycle implication, disabled during reset.
`define PTDI_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("ptdi assertion failed");

// Next-cycle implication that also holds across reset.
`define PTDI_ASSERT_NXT_ANY(lbl, a, c) \
    lbl: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("ptdi assertion failed");

`endif

/* hdl/ptdi_pkg.sv */
// Shared types and constants for the point to depth image projector.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package ptdi_pkg;

    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 512;

    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int PROD_W      = 31;   // |coord| * focal stays below 2**31
    localparam int DEN_W       = 16;   // |z| up to 32768
    localparam int DIV_STAGES  = PROD_W;
    localparam int SUM_W       = 33;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X      = 3'd0,
        REG_FOCAL_Y      = 3'd1,
        REG_CENTER_X     = 3'd2,
        REG_CENTER_Y     = 3'd3,
        REG_IMAGE_WIDTH  = 3'd4,
        REG_IMAGE_HEIGHT = 3'd5
    } cfg_reg_t;

    localparam logic [15:0] RST_FOCAL_X      = 16'd29477;
    localparam logic [15:0] RST_FOCAL_Y      = 16'd29457;
    localparam logic [15:0] RST_CENTER_X     = 16'd21381;
    localparam logic [15:0] RST_CENTER_Y     = 16'd10868;
    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [9:0]  RST_IMAGE_HEIGHT = 10'd360;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic [9:0]         read_col;
        logic [8:0]         read_row;
    } req_t;

    typedef struct packed {
        logic [9:0]  pixel_col;
        logic [8:0]  pixel_row;
        logic [15:0] depth_mm;
    } res_t;

    // Sideband that rides along the divider
    typedef struct packed {
        logic        mode;
        logic        zero;
        logic        neg_x;
        logic        neg_y;
        logic [15:0] depth;
        logic [9:0]  read_col;
        logic [8:0]  read_row;
    } tag_t;

    // Store access control for one request
    typedef struct packed {
        logic access;
        logic write;
        logic take_read;
    } mem_ctl_t;

endpackage

/* hdl/ptdi_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, two numerators per divisor.
// Depends on ptdi_pkg.
`timescale 1ns / 1ps
module ptdi_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [ptdi_pkg::PROD_W-1:0]  num_x,
    input  logic [ptdi_pkg::PROD_W-1:0]  num_y,
    input  logic [ptdi_pkg::DEN_W-1:0]   den,
    input  ptdi_pkg::tag_t               in_tag,
    output logic                         out_valid,
    output logic [ptdi_pkg::PROD_W-1:0]  quo_x,
    output logic [ptdi_pkg::PROD_W-1:0]  quo_y,
    output ptdi_pkg::tag_t               out_tag
);
    import ptdi_pkg::*;

    localparam int N = DIV_STAGES;

    logic [DEN_W-1:0]  rem_x_w [0:N];
    logic [DEN_W-1:0]  rem_y_w [0:N];
    logic [PROD_W-1:0] num_x_w [0:N];
    logic [PROD_W-1:0] num_y_w [0:N];
    logic [PROD_W-1:0] quo_x_w [0:N];
    logic [PROD_W-1:0] quo_y_w [0:N];
    logic [DEN_W-1:0]  den_w   [0:N];
    tag_t              tag_w   [0:N];
    logic              vld_w   [0:N];

    assign rem_x_w[0] = '0;
    assign rem_y_w[0] = '0;
    assign num_x_w[0] = num_x;
    assign num_y_w[0] = num_y;
    assign quo_x_w[0] = '0;
    assign quo_y_w[0] = '0;
    assign den_w[0]   = den;
    assign tag_w[0]   = in_tag;
    assign vld_w[0]   = in_valid;

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [DEN_W-1:0]  rem_x_reg, rem_y_reg;
        logic [PROD_W-1:0] num_x_reg, num_y_reg, quo_x_reg, quo_y_reg;
        logic [DEN_W-1:0]  den_reg;
        tag_t              tag_reg;
        logic              vld_reg;
        logic [DEN_W-1:0]  trial_x, trial_y;
        logic              fit_x, fit_y;

        always_comb
        begin
            trial_x = {rem_x_w[s][DEN_W-2:0], num_x_w[s][PROD_W-1]};
            trial_y = {rem_y_w[s][DEN_W-2:0], num_y_w[s][PROD_W-1]};
            fit_x   = (trial_x >= den_w[s]);
            fit_y   = (trial_y >= den_w[s]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld_w[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_x_reg <= fit_x ? (trial_x - den_w[s]) : trial_x;
                rem_y_reg <= fit_y ? (trial_y - den_w[s]) : trial_y;
                num_x_reg <= {num_x_w[s][PROD_W-2:0], 1'b0};
                num_y_reg <= {num_y_w[s][PROD_W-2:0], 1'b0};
                quo_x_reg <= {quo_x_w[s][PROD_W-2:0], fit_x};
                quo_y_reg <= {quo_y_w[s][PROD_W-2:0], fit_y};
                den_reg   <= den_w[s];
                tag_reg   <= tag_w[s];
            end
        end

        assign rem_x_w[s+1] = rem_x_reg;
        assign rem_y_w[s+1] = rem_y_reg;
        assign num_x_w[s+1] = num_x_reg;
        assign num_y_w[s+1] = num_y_reg;
        assign quo_x_w[s+1] = quo_x_reg;
        assign quo_y_w[s+1] = quo_y_reg;
        assign den_w[s+1]   = den_reg;
        assign tag_w[s+1]   = tag_reg;
        assign vld_w[s+1]   = vld_reg;
    end

    assign out_valid = vld_w[N];
    assign quo_x     = quo_x_w[N];
    assign quo_y     = quo_y_w[N];
    assign out_tag   = tag_w[N];

endmodule

/* hdl/ptdi_pixel_map.sv */
// Turns signed quotients into clamped pixel coordinates and a store address.
// Three stages: center add, mirror and clamp, address. Depends on ptdi_pkg.
`timescale 1ns / 1ps
module ptdi_pixel_map #(
    parameter int MAX_COLS = ptdi_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = ptdi_pkg::DEF_MAX_ROWS,
    parameter int CCW      = 10,
    parameter int RCW      = 9,
    parameter int AW       = 19
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [ptdi_pkg::PROD_W-1:0]  quo_x,
    input  logic [ptdi_pkg::PROD_W-1:0]  quo_y,
    input  ptdi_pkg::tag_t               in_tag,
    input  logic [15:0]                  center_x,
    input  logic [15:0]                  center_y,
    input  logic [CCW-1:0]               col_lim,
    input  logic [RCW-1:0]               row_lim,
    output logic                         out_valid,
    output logic [AW-1:0]                addr,
    output logic [CCW-1:0]               col,
    output logic [RCW-1:0]               row,
    output logic [15:0]                  depth,
    output ptdi_pkg::mem_ctl_t           ctl
);
    import ptdi_pkg::*;

    localparam int PW = SUM_W - 6;

    // Center add
    logic signed [SUM_W-1:0] qs_x, qs_y;
    logic signed [SUM_W-1:0] sum_x_reg, sum_y_reg;
    tag_t                    tag_a_reg;
    logic                    vld_a_reg;

    always_comb
    begin
        qs_x = in_tag.neg_x ? -$signed({2'b00, quo_x}) : $signed({2'b00, quo_x});
        qs_y = in_tag.neg_y ? -$signed({2'b00, quo_y}) : $signed({2'b00, quo_y});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_x_reg <= qs_x + $signed({17'd0, center_x});
            sum_y_reg <= qs_y + $signed({17'd0, center_y});
            tag_a_reg <= in_tag;
        end
    end

    // Mirror and clamp
    logic [SUM_W-1:0] mag_x, mag_y;
    logic [PW-1:0]    pix_x, pix_y;
    logic [CCW-1:0]   col_b_next;
    logic [RCW-1:0]   row_b_next;
    logic             in_store;
    mem_ctl_t         ctl_b_next;
    logic [CCW-1:0]   col_b_reg;
    logic [RCW-1:0]   row_b_reg;
    logic [15:0]      depth_b_reg;
    mem_ctl_t         ctl_b_reg;
    logic             vld_b_reg;

    always_comb
    begin
        mag_x = sum_x_reg[SUM_W-1] ? 33'(-sum_x_reg) : 33'(sum_x_reg);
        mag_y = sum_y_reg[SUM_W-1] ? 33'(-sum_y_reg) : 33'(sum_y_reg);
        pix_x = mag_x[SUM_W-1:6];
        pix_y = mag_y[SUM_W-1:6];
        in_store = (32'(tag_a_reg.read_col) < MAX_COLS) && (32'(tag_a_reg.read_row) < MAX_ROWS);
        if (tag_a_reg.mode)
        begin
            col_b_next = CCW'(tag_a_reg.read_col);
            row_b_next = RCW'(tag_a_reg.read_row);
        end
        else if (tag_a_reg.zero)
        begin
            col_b_next = '0;
            row_b_next = '0;
        end
        else
        begin
            col_b_next = (pix_x > PW'(col_lim)) ? col_lim : pix_x[CCW-1:0];
            row_b_next = (pix_y > PW'(row_lim)) ? row_lim : pix_y[RCW-1:0];
        end
        ctl_b_next.access    = !tag_a_reg.mode || in_store;
        ctl_b_next.write     = !tag_a_reg.mode;
        ctl_b_next.take_read = tag_a_reg.mode && in_store;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_b_reg   <= col_b_next;
            row_b_reg   <= row_b_next;
            depth_b_reg <= tag_a_reg.mode ? 16'd0 : tag_a_reg.depth;
            ctl_b_reg   <= ctl_b_next;
        end
    end

    // Address
    logic [AW-1:0]  addr_c_reg;
    logic [CCW-1:0] col_c_reg;
    logic [RCW-1:0] row_c_reg;
    logic [15:0]    depth_c_reg;
    mem_ctl_t       ctl_c_reg;
    logic           vld_c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            addr_c_reg  <= AW'(32'(row_b_reg) * MAX_COLS + 32'(col_b_reg));
            col_c_reg   <= col_b_reg;
            row_c_reg   <= row_b_reg;
            depth_c_reg <= depth_b_reg;
            ctl_c_reg   <= ctl_b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= in_valid;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    assign out_valid = vld_c_reg;
    assign addr      = addr_c_reg;
    assign col       = col_c_reg;
    assign row       = row_c_reg;
    assign depth     = depth_c_reg;
    assign ctl       = ctl_c_reg;

endmodule

/* hdl/ptdi_depth_store.sv */
// Depth pixel store: single port, read-first, with a clearing sweep after reset.
// Depends on ptdi_pkg.
`timescale 1ns / 1ps
module ptdi_depth_store #(
    parameter int DEPTH = ptdi_pkg::DEF_MAX_COLS * ptdi_pkg::DEF_MAX_ROWS,
    parameter int AW    = 19
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                access,
    input  logic                write,
    input  logic [AW-1:0]       addr,
    input  logic [15:0]         wdata,
    output logic [15:0]         rdata,
    output logic                busy
);
    logic [15:0]   mem [0:DEPTH-1];
    logic [15:0]   rdata_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          busy_reg;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0]   mem_wd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (32'(clr_addr_reg) == DEPTH - 1)
                busy_reg <= 1'b0;
        end
    end

    // Every access writes: a point stores its depth, a read stores zero
    always_comb
    begin
        mem_we   = busy_reg || access;
        mem_addr = busy_reg ? clr_addr_reg : addr;
        mem_wd   = (busy_reg || !write) ? 16'd0 : wdata;
    end

    // Read returns the old word; a read request then clears it
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wd;
        if (access)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule

/* hdl/point_to_depth_image_projector.sv */
// Pinhole projector from 3D points to a depth image with a read-and-clear port.
// Throughput is one request per cycle unless the result is held or the store sweeps.
// The pipeline is a multiply stage, a 31-stage bit-per-stage divider, three mapping
// stages and the store access stage; it stalls as a whole when the result is held.
// Reset clears the valid flags and loads configuration defaults at once, then sweeps
// the store to zero with req_ready low; configuration writes are taken throughout.
`timescale 1ns / 1ps
module point_to_depth_image_projector #(
    parameter int MAX_COLS = ptdi_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = ptdi_pkg::DEF_MAX_ROWS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  ptdi_pkg::req_t                 req_data,
    output logic                           res_valid,
    input  logic                           res_ready,
    output ptdi_pkg::res_t                 res_data,
    input  logic                           cfg_we,
    input  logic [ptdi_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [ptdi_pkg::CFG_W-1:0]     cfg_wdata
);
    import ptdi_pkg::*;

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CCW   = (CW > 10) ? CW : 10;
    localparam int RCW   = (RW > 9) ? RW : 9;
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    // Configuration
    logic [15:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [10:0] image_width_reg;
    logic [9:0]  image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg      <= RST_FOCAL_X;
            focal_y_reg      <= RST_FOCAL_Y;
            center_x_reg     <= RST_CENTER_X;
            center_y_reg     <= RST_CENTER_Y;
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_FOCAL_X:      focal_x_reg      <= cfg_wdata;
                REG_FOCAL_Y:      focal_y_reg      <= cfg_wdata;
                REG_CENTER_X:     center_x_reg     <= cfg_wdata;
                REG_CENTER_Y:     center_y_reg     <= cfg_wdata;
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[10:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[9:0];
                default:          ;
            endcase
        end
    end

    // Last usable column and row
    logic [CCW-1:0] col_lim;
    logic [RCW-1:0] row_lim;

    always_comb
    begin
        if (image_width_reg == '0)
            col_lim = '0;
        else if (32'(image_width_reg) > MAX_COLS)
            col_lim = CCW'(MAX_COLS - 1);
        else
            col_lim = CCW'(image_width_reg - 11'd1);
        if (image_height_reg == '0)
            row_lim = '0;
        else if (32'(image_height_reg) > MAX_ROWS)
            row_lim = RCW'(MAX_ROWS - 1);
        else
            row_lim = RCW'(image_height_reg - 10'd1);
    end

    // Handshake
    logic res_valid_reg;
    logic advance;
    logic busy;
    logic accept;

    assign advance   = !res_valid_reg || res_ready;
    assign req_ready = advance && !busy;
    assign accept    = req_valid && req_ready;

    // Multiply stage: magnitudes and signs
    logic [15:0]        abs_x, abs_y, abs_z;
    logic [31:0]        prod_x, prod_y;
    tag_t               tag_m_next;
    logic [PROD_W-1:0]  prod_x_reg, prod_y_reg;
    logic [DEN_W-1:0]   den_reg;
    tag_t               tag_m_reg;
    logic               vld_m_reg;

    always_comb
    begin
        abs_x  = req_data.point_x[15] ? (~req_data.point_x + 16'd1) : req_data.point_x;
        abs_y  = req_data.point_y[15] ? (~req_data.point_y + 16'd1) : req_data.point_y;
        abs_z  = req_data.point_z[15] ? (~req_data.point_z + 16'd1) : req_data.point_z;
        prod_x = abs_x * focal_x_reg;
        prod_y = abs_y * focal_y_reg;
        tag_m_next.mode     = req_data.mode;
        tag_m_next.zero     = (req_data.point_z == '0);
        tag_m_next.neg_x    = req_data.point_x[15] ^ req_data.point_z[15];
        tag_m_next.neg_y    = req_data.point_y[15] ^ req_data.point_z[15];
        tag_m_next.depth    = req_data.point_z[15] ? 16'd0 : req_data.point_z;
        tag_m_next.read_col = req_data.read_col;
        tag_m_next.read_row = req_data.read_row;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_x_reg <= prod_x[PROD_W-1:0];
            prod_y_reg <= prod_y[PROD_W-1:0];
            den_reg    <= abs_z;
            tag_m_reg  <= tag_m_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_m_reg <= 1'b0;
        else if (advance)
            vld_m_reg <= accept;
    end

    // Divide
    logic              vld_d;
    logic [PROD_W-1:0] quo_x, quo_y;
    tag_t              tag_d;

    ptdi_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (vld_m_reg),
        .num_x     (prod_x_reg),
        .num_y     (prod_y_reg),
        .den       (den_reg),
        .in_tag    (tag_m_reg),
        .out_valid (vld_d),
        .quo_x     (quo_x),
        .quo_y     (quo_y),
        .out_tag   (tag_d)
    );

    // Map to pixel
    logic           vld_p;
    logic [AW-1:0]  addr_p;
    logic [CCW-1:0] col_p;
    logic [RCW-1:0] row_p;
    logic [15:0]    depth_p;
    mem_ctl_t       ctl_p;

    ptdi_pixel_map #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .CCW      (CCW),
        .RCW      (RCW),
        .AW       (AW)
    ) u_pixel_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (vld_d),
        .quo_x     (quo_x),
        .quo_y     (quo_y),
        .in_tag    (tag_d),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .col_lim   (col_lim),
        .row_lim   (row_lim),
        .out_valid (vld_p),
        .addr      (addr_p),
        .col       (col_p),
        .row       (row_p),
        .depth     (depth_p),
        .ctl       (ctl_p)
    );

    // Store access and result register
    logic [15:0] rdata;

    ptdi_depth_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_depth_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .access (advance && vld_p && ctl_p.access),
        .write  (ctl_p.write),
        .addr   (addr_p),
        .wdata  (depth_p),
        .rdata  (rdata),
        .busy   (busy)
    );

    logic [9:0]  res_col_reg;
    logic [8:0]  res_row_reg;
    logic [15:0] res_depth_reg;
    logic        take_read_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_col_reg   <= col_p[9:0];
            res_row_reg   <= row_p[8:0];
            res_depth_reg <= depth_p;
            take_read_reg <= ctl_p.take_read;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= vld_p;
    end

    assign res_valid          = res_valid_reg;
    assign res_data.pixel_col = res_col_reg;
    assign res_data.pixel_row = res_row_reg;
    assign res_data.depth_mm  = take_read_reg ? rdata : res_depth_reg;

endmodule

/* hdl/ptdi_checker.sv */
// Port-level checker for the depth image projector, bound to the top level.
// Depends on ptdi_pkg and the projector assertion macros.
`timescale 1ns / 1ps
`include "point_to_depth_image_projector_macros.svh"
module ptdi_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_ready,
    input  logic           res_valid,
    input  logic           res_ready,
    input  ptdi_pkg::res_t res_data
);
    // Held result stays put
    `PTDI_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data))
    // Store sweep keeps requests out right after reset
    `PTDI_ASSERT_NXT_ANY(a_sweep_blocks, !rst_n, !req_ready)
    // Nothing comes out right after reset
    `PTDI_ASSERT_NXT_ANY(a_reset_empty, !rst_n, !res_valid)
    // Blocked with no pending result means the sweep, so the pipeline is empty
    `PTDI_ASSERT_NXT(a_sweep_empty, !req_ready && !res_valid, !res_valid)

endmodule

bind point_to_depth_image_projector ptdi_checker u_ptdi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);
